// ----- rtl/sme_pkg.sv -----
// Shared types and constants for the stack machine execute block.
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

    localparam logic [7:0] OP_HALT      = 8'd0;
    localparam logic [7:0] OP_JMP       = 8'd1;
    localparam logic [7:0] OP_JNZ       = 8'd2;
    localparam logic [7:0] OP_DUP       = 8'd3;
    localparam logic [7:0] OP_SWAP      = 8'd4;
    localparam logic [7:0] OP_DROP      = 8'd5;
    localparam logic [7:0] OP_PUSH_WORD = 8'd6;
    localparam logic [7:0] OP_PUSH_HALF = 8'd7;
    localparam logic [7:0] OP_PUSH_BYTE = 8'd8;
    localparam logic [7:0] OP_ADD       = 8'd9;
    localparam logic [7:0] OP_SUB       = 8'd10;
    localparam logic [7:0] OP_MUL       = 8'd11;
    localparam logic [7:0] OP_DIV       = 8'd12;
    localparam logic [7:0] OP_MOD       = 8'd13;
    localparam logic [7:0] OP_EQ        = 8'd14;
    localparam logic [7:0] OP_NE        = 8'd15;
    localparam logic [7:0] OP_LT        = 8'd16;
    localparam logic [7:0] OP_GT        = 8'd17;
    localparam logic [7:0] OP_LE        = 8'd18;
    localparam logic [7:0] OP_GE        = 8'd19;
    localparam logic [7:0] OP_NOT       = 8'd20;
    localparam logic [7:0] OP_AND       = 8'd21;
    localparam logic [7:0] OP_OR        = 8'd22;
    localparam logic [7:0] OP_IN        = 8'd23;
    localparam logic [7:0] OP_OUT       = 8'd24;
    localparam logic [7:0] OP_TICKS     = 8'h2A;

    typedef enum logic [3:0] {
        C_HALT, C_JMP, C_JNZ, C_DUP, C_SWAP, C_DROP, C_PUSH,
        C_BIN, C_NOT, C_OUT, C_CLOCK, C_UNDEF
    } cls_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_UNDEF = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RDA, S_RDB, S_RDL, S_EXEC, S_DIV, S_WR2, S_RESULT
    } state_t;

    typedef struct packed {
        logic [7:0]  kind;
        cls_t        cls;
        logic [2:0]  len;
        logic [31:0] imm;
        logic [31:0] push_val;
    } item_t;

endpackage
`default_nettype wire

// ----- rtl/sme_front.sv -----
// Front part: accepts items, classifies the opcode and queues them.
`timescale 1ns / 1ps
`default_nettype none
module sme_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          kind,
    input  wire logic signed [31:0]  immediate,
    input  wire logic signed [31:0]  in_value,
    output logic                     q_valid,
    input  wire logic                q_pop,
    output sme_pkg::item_t           q_item
);

    sme_pkg::item_t ent_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    sme_pkg::item_t dec;
    logic           push;

    // Classify the opcode and pick the instruction length
    always_comb
    begin
        dec.kind     = kind;
        dec.imm      = immediate;
        dec.push_val = immediate;
        dec.len      = 3'd1;
        dec.cls      = sme_pkg::C_UNDEF;
        unique case (kind)
            sme_pkg::OP_HALT:  dec.cls = sme_pkg::C_HALT;
            sme_pkg::OP_JMP:   dec.cls = sme_pkg::C_JMP;
            sme_pkg::OP_JNZ:
            begin
                dec.cls = sme_pkg::C_JNZ;
                dec.len = 3'd3;
            end
            sme_pkg::OP_DUP:
            begin
                dec.cls = sme_pkg::C_DUP;
                dec.len = 3'd2;
            end
            sme_pkg::OP_SWAP:
            begin
                dec.cls = sme_pkg::C_SWAP;
                dec.len = 3'd2;
            end
            sme_pkg::OP_DROP:  dec.cls = sme_pkg::C_DROP;
            sme_pkg::OP_PUSH_WORD:
            begin
                dec.cls = sme_pkg::C_PUSH;
                dec.len = 3'd5;
            end
            sme_pkg::OP_PUSH_HALF:
            begin
                dec.cls = sme_pkg::C_PUSH;
                dec.len = 3'd3;
            end
            sme_pkg::OP_PUSH_BYTE:
            begin
                dec.cls = sme_pkg::C_PUSH;
                dec.len = 3'd2;
            end
            sme_pkg::OP_IN:
            begin
                dec.cls      = sme_pkg::C_PUSH;
                dec.push_val = in_value;
            end
            sme_pkg::OP_NOT:   dec.cls = sme_pkg::C_NOT;
            sme_pkg::OP_OUT:   dec.cls = sme_pkg::C_OUT;
            sme_pkg::OP_TICKS: dec.cls = sme_pkg::C_CLOCK;
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
            sme_pkg::OP_MOD, sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT,
            sme_pkg::OP_GT, sme_pkg::OP_LE, sme_pkg::OP_GE, sme_pkg::OP_AND,
            sme_pkg::OP_OR:    dec.cls = sme_pkg::C_BIN;
            default:           dec.cls = sme_pkg::C_UNDEF;
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rp_reg];
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = ~wp_reg;
        end
        if (q_pop && q_valid)
        begin
            rp_next = ~rp_reg;
        end
        case ({push, q_pop && q_valid})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= dec;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sme_div.sv -----
// Iterative signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sme_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        is_mod,
    input  wire logic [31:0] dvd,
    input  wire logic [31:0] dvs,
    output logic             done,
    output logic [31:0]      result
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] mb_reg;
    logic        negq_reg;
    logic        negr_reg;
    logic        mod_reg;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign diff   = rem_sh - {1'b0, mb_reg};
    assign done   = done_reg;

    always_comb
    begin
        if (mod_reg)
        begin
            result = negr_reg ? (32'd0 - rem_reg) : rem_reg;
        end
        else
        begin
            result = negq_reg ? (32'd0 - quo_reg) : quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dvd[31] ? (32'd0 - dvd) : dvd;
            mb_reg   <= dvs[31] ? (32'd0 - dvs) : dvs;
            rem_reg  <= 32'd0;
            negq_reg <= dvd[31] ^ dvs[31];
            negr_reg <= dvd[31];
            mod_reg  <= is_mod;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], ~diff[32]};
            rem_reg <= diff[32] ? rem_sh[31:0] : diff[31:0];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sme_back.sv -----
// Back part: runs queued instructions against the stack memory.
`timescale 1ns / 1ps
`default_nettype none
module sme_back #(
    parameter int STACK_DEPTH    = 1024,
    parameter int CODE_ADDR_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  sme_pkg::item_t      q_item,
    output logic                res_valid,
    input  wire logic           res_stall,
    output logic [15:0]         next_pc,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                ticks_valid,
    output logic [31:0]         elapsed_ticks,
    output logic                halted,
    output logic [2:0]          status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = AW + 1;
    localparam int PW = CODE_ADDR_BITS;
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    sme_pkg::state_t  state_reg, state_next;
    sme_pkg::item_t   cur_reg, cur_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [PW-1:0]    pc_reg, pc_next;
    logic [31:0]      tick_reg, tick_next;
    logic             halt_reg, halt_next;
    logic [31:0]      a_reg, a_next;
    logic [31:0]      b_reg, b_next;
    logic [31:0]      l_reg, l_next;
    logic [AW-1:0]    loc_reg, loc_next;

    logic [PW-1:0]    rpc_reg, rpc_next;
    logic             rov_reg, rov_next;
    logic [7:0]       rob_reg, rob_next;
    logic             rtv_reg, rtv_next;
    logic [31:0]      rtk_reg, rtk_next;
    logic             rhalt_reg, rhalt_next;
    sme_pkg::status_t rst_reg, rst_next;

    logic [31:0]      mem [STACK_DEPTH];
    logic [31:0]      rd_data_reg;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [31:0]      mem_wd;

    logic             div_start, div_done;
    logic [31:0]      div_result;

    logic [DW-1:0]    dm1, dm2;
    logic [31:0]      d32, dup_off, swap_off;
    logic [AW-1:0]    dup_loc, swap_loc;
    logic [31:0]      alu_r;
    sme_pkg::status_t fault;

    assign dm1      = depth_reg - DW'(1);
    assign dm2      = depth_reg - DW'(2);
    assign d32      = 32'(depth_reg);
    assign dup_off  = d32 - 32'd1 - q_item.imm;
    assign swap_off = d32 - q_item.imm;

    // Source of DUP and target of SWAP, clamped to the bottom word
    always_comb
    begin
        if (q_item.imm[31])
        begin
            dup_loc = dm1[AW-1:0];
        end
        else if (q_item.imm >= d32)
        begin
            dup_loc = '0;
        end
        else
        begin
            dup_loc = dup_off[AW-1:0];
        end
        if (q_item.imm[31] || q_item.imm == 32'd0)
        begin
            swap_loc = dm1[AW-1:0];
        end
        else if (q_item.imm > d32)
        begin
            swap_loc = '0;
        end
        else
        begin
            swap_loc = swap_off[AW-1:0];
        end
    end

    // Depth check at issue
    always_comb
    begin
        fault = sme_pkg::ST_OK;
        case (q_item.cls)
            sme_pkg::C_BIN:
                if (depth_reg < DW'(2)) fault = sme_pkg::ST_EMPTY;
            sme_pkg::C_JNZ, sme_pkg::C_NOT, sme_pkg::C_OUT, sme_pkg::C_SWAP,
            sme_pkg::C_DROP:
                if (depth_reg == '0) fault = sme_pkg::ST_EMPTY;
            sme_pkg::C_DUP:
                if (depth_reg == '0) fault = sme_pkg::ST_EMPTY;
                else if (depth_reg == FULL) fault = sme_pkg::ST_FULL;
            sme_pkg::C_PUSH:
                if (depth_reg == FULL) fault = sme_pkg::ST_FULL;
            sme_pkg::C_UNDEF:
                fault = sme_pkg::ST_UNDEF;
            default:
                fault = sme_pkg::ST_OK;
        endcase
    end

    // Comparisons follow the machine's own convention (LT means a > b)
    always_comb
    begin
        case (cur_reg.kind)
            sme_pkg::OP_ADD: alu_r = a_reg + b_reg;
            sme_pkg::OP_SUB: alu_r = a_reg - b_reg;
            sme_pkg::OP_MUL: alu_r = a_reg * b_reg;
            sme_pkg::OP_EQ:  alu_r = 32'(a_reg == b_reg);
            sme_pkg::OP_NE:  alu_r = 32'(a_reg != b_reg);
            sme_pkg::OP_LT:  alu_r = 32'($signed(b_reg) < $signed(a_reg));
            sme_pkg::OP_GT:  alu_r = 32'($signed(a_reg) < $signed(b_reg));
            sme_pkg::OP_LE:  alu_r = 32'(!($signed(a_reg) < $signed(b_reg)));
            sme_pkg::OP_GE:  alu_r = 32'(!($signed(b_reg) < $signed(a_reg)));
            sme_pkg::OP_AND: alu_r = 32'(a_reg != 32'd0 && b_reg != 32'd0);
            sme_pkg::OP_OR:  alu_r = 32'(a_reg != 32'd0 || b_reg != 32'd0);
            default:         alu_r = 32'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        depth_next = depth_reg;
        pc_next    = pc_reg;
        tick_next  = tick_reg;
        halt_next  = halt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        l_next     = l_reg;
        loc_next   = loc_reg;
        rpc_next   = rpc_reg;
        rov_next   = rov_reg;
        rob_next   = rob_reg;
        rtv_next   = rtv_reg;
        rtk_next   = rtk_reg;
        rhalt_next = rhalt_reg;
        rst_next   = rst_reg;
        mem_we     = 1'b0;
        mem_wa     = depth_reg[AW-1:0];
        mem_wd     = 32'd0;
        mem_re     = 1'b0;
        mem_ra     = dm1[AW-1:0];
        div_start  = 1'b0;
        q_pop      = 1'b0;

        unique case (state_reg)
            sme_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    rov_next   = 1'b0;
                    rob_next   = 8'd0;
                    rtv_next   = 1'b0;
                    rtk_next   = 32'd0;
                    rst_next   = sme_pkg::ST_OK;
                    rhalt_next = halt_reg;
                    rpc_next   = pc_reg;
                    state_next = sme_pkg::S_RESULT;
                    if (!halt_reg)
                    begin
                        tick_next = tick_reg + 32'd1;
                        if (fault != sme_pkg::ST_OK || q_item.cls == sme_pkg::C_HALT)
                        begin
                            halt_next  = 1'b1;
                            rhalt_next = 1'b1;
                            rst_next   = fault;
                        end
                        else
                        begin
                            case (q_item.cls)
                                sme_pkg::C_JMP:
                                begin
                                    pc_next  = q_item.imm[PW-1:0];
                                    rpc_next = q_item.imm[PW-1:0];
                                end
                                sme_pkg::C_CLOCK:
                                begin
                                    rtv_next = 1'b1;
                                    rtk_next = tick_reg + 32'd1;
                                    pc_next  = pc_reg + PW'(q_item.len);
                                    rpc_next = pc_reg + PW'(q_item.len);
                                end
                                sme_pkg::C_PUSH:
                                begin
                                    mem_we     = 1'b1;
                                    mem_wd     = q_item.push_val;
                                    depth_next = depth_reg + DW'(1);
                                    pc_next    = pc_reg + PW'(q_item.len);
                                    rpc_next   = pc_reg + PW'(q_item.len);
                                end
                                sme_pkg::C_DROP:
                                begin
                                    depth_next = dm1;
                                    pc_next    = pc_reg + PW'(q_item.len);
                                    rpc_next   = pc_reg + PW'(q_item.len);
                                end
                                sme_pkg::C_BIN:
                                begin
                                    mem_re     = 1'b1;
                                    mem_ra     = dm2[AW-1:0];
                                    state_next = sme_pkg::S_RDA;
                                end
                                sme_pkg::C_DUP:
                                begin
                                    mem_re     = 1'b1;
                                    mem_ra     = dup_loc;
                                    state_next = sme_pkg::S_RDL;
                                end
                                default:
                                begin
                                    // JNZ, NOT, OUT, SWAP start from the top word
                                    loc_next   = swap_loc;
                                    mem_re     = 1'b1;
                                    state_next = sme_pkg::S_RDB;
                                end
                            endcase
                        end
                    end
                end
            end

            sme_pkg::S_RDA:
            begin
                a_next     = rd_data_reg;
                mem_re     = 1'b1;
                state_next = sme_pkg::S_RDB;
            end

            sme_pkg::S_RDB:
            begin
                b_next = rd_data_reg;
                if (cur_reg.cls == sme_pkg::C_SWAP)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = loc_reg;
                    state_next = sme_pkg::S_RDL;
                end
                else
                begin
                    state_next = sme_pkg::S_EXEC;
                end
            end

            sme_pkg::S_RDL:
            begin
                l_next     = rd_data_reg;
                state_next = sme_pkg::S_EXEC;
            end

            sme_pkg::S_EXEC:
            begin
                state_next = sme_pkg::S_RESULT;
                pc_next    = pc_reg + PW'(cur_reg.len);
                rpc_next   = pc_reg + PW'(cur_reg.len);
                case (cur_reg.cls)
                    sme_pkg::C_JNZ:
                    begin
                        if (b_reg != 32'd0)
                        begin
                            pc_next  = cur_reg.imm[PW-1:0];
                            rpc_next = cur_reg.imm[PW-1:0];
                        end
                    end
                    sme_pkg::C_NOT:
                    begin
                        mem_we = 1'b1;
                        mem_wa = dm1[AW-1:0];
                        mem_wd = 32'(b_reg == 32'd0);
                    end
                    sme_pkg::C_OUT:
                    begin
                        depth_next = dm1;
                        rov_next   = 1'b1;
                        rob_next   = b_reg[7:0];
                    end
                    sme_pkg::C_DUP:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = l_reg;
                        depth_next = depth_reg + DW'(1);
                    end
                    sme_pkg::C_SWAP:
                    begin
                        mem_we     = 1'b1;
                        mem_wa     = loc_reg;
                        mem_wd     = b_reg;
                        state_next = sme_pkg::S_WR2;
                    end
                    default:
                    begin
                        if (cur_reg.kind == sme_pkg::OP_DIV || cur_reg.kind == sme_pkg::OP_MOD)
                        begin
                            if (b_reg == 32'd0)
                            begin
                                pc_next    = pc_reg;
                                rpc_next   = pc_reg;
                                halt_next  = 1'b1;
                                rhalt_next = 1'b1;
                                rst_next   = sme_pkg::ST_DIVZ;
                            end
                            else
                            begin
                                pc_next    = pc_reg;
                                div_start  = 1'b1;
                                state_next = sme_pkg::S_DIV;
                            end
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wa     = dm2[AW-1:0];
                            mem_wd     = alu_r;
                            depth_next = dm1;
                        end
                    end
                endcase
            end

            sme_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = dm2[AW-1:0];
                    mem_wd     = div_result;
                    depth_next = dm1;
                    pc_next    = pc_reg + PW'(cur_reg.len);
                    rpc_next   = pc_reg + PW'(cur_reg.len);
                    state_next = sme_pkg::S_RESULT;
                end
            end

            sme_pkg::S_WR2:
            begin
                mem_we     = 1'b1;
                mem_wa     = dm1[AW-1:0];
                mem_wd     = l_reg;
                state_next = sme_pkg::S_RESULT;
            end

            sme_pkg::S_RESULT:
            begin
                if (!res_stall)
                begin
                    state_next = sme_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sme_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sme_pkg::S_IDLE;
            depth_reg <= '0;
            pc_reg    <= '0;
            tick_reg  <= 32'd0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            pc_reg    <= pc_next;
            tick_reg  <= tick_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        l_reg     <= l_next;
        loc_reg   <= loc_next;
        rpc_reg   <= rpc_next;
        rov_reg   <= rov_next;
        rob_reg   <= rob_next;
        rtv_reg   <= rtv_next;
        rtk_reg   <= rtk_next;
        rhalt_reg <= rhalt_next;
        rst_reg   <= rst_next;
    end

    // Stack memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    sme_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .is_mod (cur_reg.kind == sme_pkg::OP_MOD),
        .dvd    (a_reg),
        .dvs    (b_reg),
        .done   (div_done),
        .result (div_result)
    );

    assign res_valid     = (state_reg == sme_pkg::S_RESULT);
    assign next_pc       = 16'(rpc_reg);
    assign out_valid     = rov_reg;
    assign out_byte      = rob_reg;
    assign ticks_valid   = rtv_reg;
    assign elapsed_ticks = rtk_reg;
    assign halted        = rhalt_reg;
    assign status        = rst_reg;

endmodule
`default_nettype wire

// ----- rtl/stack_machine_execute_top.sv -----
// Top level of the stack machine execute block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | kind, immediate, in_value
//  result   | res_valid / res_stall| next_pc, out_valid, out_byte, ticks_valid,
//           |                      | elapsed_ticks, halted, status
//
// One item is executed at a time by the back sequencer; the front queue holds
// up to two items so the input side keeps moving while an item executes.
// Push, drop, jmp, clock, halt, faults found at issue and items arriving while
// halted go straight to the result; jnz, not, out, dup, swap and the ALU ops
// first read their operands through the single read port of the stack memory;
// div and mod then wait for the 32-step divider unless the divisor is zero.
// Reset clears depth, pc, ticks and halt; the stack needs no clearing pass
// since only words below the depth are ever read.
// A stalled result holds its fields and the back part waits for it.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute_top #(
    parameter int STACK_DEPTH    = 1024,
    parameter int CODE_ADDR_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         kind,
    input  wire logic signed [31:0] immediate,
    input  wire logic signed [31:0] in_value,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [15:0]             next_pc,
    output logic                    out_valid,
    output logic [7:0]              out_byte,
    output logic                    ticks_valid,
    output logic [31:0]             elapsed_ticks,
    output logic                    halted,
    output logic [2:0]              status
);

    logic           q_valid;
    logic           q_pop;
    sme_pkg::item_t q_item;

    // Front: accept and classify
    sme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .immediate (immediate),
        .in_value  (in_value),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    // Back: execute against the stack and present one result
    sme_back #(
        .STACK_DEPTH    (STACK_DEPTH),
        .CODE_ADDR_BITS (CODE_ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .next_pc       (next_pc),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .ticks_valid   (ticks_valid),
        .elapsed_ticks (elapsed_ticks),
        .halted        (halted),
        .status        (status)
    );

endmodule
`default_nettype wire

// ----- rtl/sme_checker.sv -----
// Port-level checks for the stack machine execute block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module sme_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [15:0] next_pc,
    input wire logic        out_valid,
    input wire logic        ticks_valid,
    input wire logic        halted,
    input wire logic [2:0]  status
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_hold_pc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(next_pc))
        else $error("next_pc changed while stalled");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != sme_pkg::ST_OK |-> halted)
        else $error("fault without halt");

    a_out_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (out_valid || ticks_valid) |-> !halted)
        else $error("output byte or ticks on a halted result");

    a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(out_valid && ticks_valid))
        else $error("out and ticks reported together");

endmodule

bind stack_machine_execute_top sme_checker u_sme_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .next_pc     (next_pc),
    .out_valid   (out_valid),
    .ticks_valid (ticks_valid),
    .halted      (halted),
    .status      (status)
);
`default_nettype wire
